/* rtl/dsw_pkg.sv */
package dsw_pkg;

	localparam int SUM_MAX = 64;
	localparam int ROW_DEPTH = SUM_MAX + 1;
	localparam int ADDR_W = $clog2(ROW_DEPTH);
	localparam int VAL_W = 7;
	localparam int CNT_W = 64;
	localparam int DATA_W = 32;
	localparam int PADDR_W = 3;

	// register index, taken from paddr[2]
	localparam logic REG_FACE = 1'b0;
	localparam logic REG_DICE = 1'b1;

	localparam logic [VAL_W-1:0] FACE_RESET = VAL_W'(6);
	localparam logic [VAL_W-1:0] DICE_RESET = VAL_W'(3);

	typedef struct packed {
		logic [VAL_W-1:0] face_count;
		logic [VAL_W-1:0] dice_count;
	} cfg_t;

endpackage

/* rtl/dice_sum_way_counter.sv */
// Channel     Ports                                         Direction
// config      psel penable pwrite paddr pwdata prdata pready  APB slave
// command     start target_sum / busy                       in, taken when start & !busy
// result      done way_count                                out, one-cycle strobe
//
// Each transaction sweeps sums 1..target once per die, one sum per cycle, through
// two row memories used in ping-pong. Out-of-range targets, zero dice, target zero
// and targets below dice_count are answered without a sweep. The rate is set by
// the single window adder.
// Reset returns face_count to 6 and dice_count to 3; row memories need no clearing.
// The receiver cannot stall: done and way_count are valid for exactly one cycle.
module dice_sum_way_counter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsw_pkg::DATA_W-1:0]   pwdata,
	output logic [dsw_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	input  logic                         start,
	input  logic [dsw_pkg::VAL_W-1:0]    target_sum,
	output logic                         busy,
	output logic                         done,
	output logic [dsw_pkg::CNT_W-1:0]    way_count
);

	dsw_pkg::cfg_t cfg;

	dsw_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dsw_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.start      (start),
		.target_sum (target_sum),
		.busy       (busy),
		.done       (done),
		.way_count  (way_count)
	);

endmodule

/* rtl/dsw_ram.sv */
module dsw_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

/* rtl/dsw_regs.sv */
module dsw_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [dsw_pkg::PADDR_W-1:0]  paddr,
	input  logic [dsw_pkg::DATA_W-1:0]   pwdata,
	output logic [dsw_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output dsw_pkg::cfg_t                cfg
);

	logic                       wr_en;
	logic                       reg_idx;
	logic [dsw_pkg::VAL_W-1:0]  face_q;
	logic [dsw_pkg::VAL_W-1:0]  dice_q;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_q <= dsw_pkg::FACE_RESET;
			dice_q <= dsw_pkg::DICE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				dsw_pkg::REG_FACE: face_q <= pwdata[dsw_pkg::VAL_W-1:0];
				dsw_pkg::REG_DICE: dice_q <= pwdata[dsw_pkg::VAL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			dsw_pkg::REG_FACE: prdata = {{(dsw_pkg::DATA_W-dsw_pkg::VAL_W){1'b0}}, face_q};
			dsw_pkg::REG_DICE: prdata = {{(dsw_pkg::DATA_W-dsw_pkg::VAL_W){1'b0}}, dice_q};
			default:           prdata = '0;
		endcase
	end

	assign cfg.face_count = face_q;
	assign cfg.dice_count = dice_q;

endmodule

/* rtl/dsw_engine.sv */
module dsw_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dsw_pkg::cfg_t                cfg,
	input  logic                         start,
	input  logic [dsw_pkg::VAL_W-1:0]    target_sum,
	output logic                         busy,
	output logic                         done,
	output logic [dsw_pkg::CNT_W-1:0]    way_count
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN
	} state_t;

	localparam int AW = dsw_pkg::ADDR_W;
	localparam int VW = dsw_pkg::VAL_W;
	localparam int CW = dsw_pkg::CNT_W;

	state_t           state_q;
	logic [VW-1:0]    tgt_q;
	logic [VW-1:0]    die_q;
	logic [VW-1:0]    s_q;
	logic             bank_q;
	logic             first_die_q;
	logic             done_q;
	logic [CW-1:0]    way_q;
	logic [CW-1:0]    win_q;

	// read stage
	logic             v_s1;
	logic [AW-1:0]    waddr_s1;
	logic             wbank_s1;
	logic             first_s1;
	logic             last_s1;
	logic             force_a_s1;
	logic             aval_s1;
	logic             force_b_s1;
	logic             bval_s1;

	logic [VW-1:0]    addr_a;
	logic [VW:0]      diff_b;
	logic             force_a;
	logic             aval;
	logic             force_b;
	logic             bval;
	logic             last_s;
	logic             last_die;

	logic [CW-1:0]    rd_a_bank0;
	logic [CW-1:0]    rd_b_bank0;
	logic [CW-1:0]    rd_a_bank1;
	logic [CW-1:0]    rd_b_bank1;
	logic [CW-1:0]    a_val;
	logic [CW-1:0]    b_val;
	logic [CW-1:0]    win_next;

	logic             accept;
	logic [CW-1:0]    quick_val;
	logic             quick;
	logic             tgt_over;

	assign accept   = start & (state_q == ST_IDLE);
	assign tgt_over = target_sum > VW'(dsw_pkg::SUM_MAX);

	// cases answered without a sweep
	always_comb begin
		quick     = 1'b1;
		quick_val = '0;
		if (tgt_over) begin
			quick_val = '0;
		end else if (cfg.dice_count == '0) begin
			quick_val = CW'(target_sum == '0);
		end else if (target_sum == '0 || cfg.dice_count > target_sum) begin
			quick_val = '0;
		end else begin
			quick = 1'b0;
		end
	end

	// issue addresses: window adds prev[s-1] and drops prev[s-1-face]
	always_comb begin
		addr_a  = s_q - VW'(1);
		diff_b  = {1'b0, s_q} - (VW+1)'(1) - {1'b0, cfg.face_count};
		force_a = first_die_q | (addr_a == '0);
		aval    = first_die_q & (addr_a == '0);
		force_b = first_die_q | diff_b[VW] | (diff_b[VW-1:0] == '0);
		bval    = first_die_q & ~diff_b[VW] & (diff_b[VW-1:0] == '0);
		last_s  = (s_q == tgt_q);
		last_die = (die_q == cfg.dice_count);
	end

	// combine stage: bank opposite to the write bank holds the previous row
	always_comb begin
		if (force_a_s1) begin
			a_val = CW'(aval_s1);
		end else if (wbank_s1) begin
			a_val = rd_a_bank0;
		end else begin
			a_val = rd_a_bank1;
		end
		if (force_b_s1) begin
			b_val = CW'(bval_s1);
		end else if (wbank_s1) begin
			b_val = rd_b_bank0;
		end else begin
			b_val = rd_b_bank1;
		end
		win_next = (first_s1 ? '0 : win_q) + a_val - b_val;
	end

	dsw_ram #(
		.WIDTH(CW),
		.DEPTH(dsw_pkg::ROW_DEPTH)
	) u_bank0 (
		.clk     (clk),
		.we      (v_s1 & ~wbank_s1),
		.waddr   (waddr_s1),
		.wdata   (win_next),
		.raddr_a (addr_a[AW-1:0]),
		.rdata_a (rd_a_bank0),
		.raddr_b (diff_b[AW-1:0]),
		.rdata_b (rd_b_bank0)
	);

	dsw_ram #(
		.WIDTH(CW),
		.DEPTH(dsw_pkg::ROW_DEPTH)
	) u_bank1 (
		.clk     (clk),
		.we      (v_s1 & wbank_s1),
		.waddr   (waddr_s1),
		.wdata   (win_next),
		.raddr_a (addr_a[AW-1:0]),
		.rdata_a (rd_a_bank1),
		.raddr_b (diff_b[AW-1:0]),
		.rdata_b (rd_b_bank1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tgt_q       <= '0;
			die_q       <= '0;
			s_q         <= '0;
			bank_q      <= 1'b0;
			first_die_q <= 1'b0;
			done_q      <= 1'b0;
			way_q       <= '0;
			win_q       <= '0;
			v_s1        <= 1'b0;
			waddr_s1    <= '0;
			wbank_s1    <= 1'b0;
			first_s1    <= 1'b0;
			last_s1     <= 1'b0;
			force_a_s1  <= 1'b0;
			aval_s1     <= 1'b0;
			force_b_s1  <= 1'b0;
			bval_s1     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			v_s1   <= 1'b0;

			if (v_s1) begin
				win_q <= win_next;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (quick) begin
							done_q <= 1'b1;
							way_q  <= quick_val;
						end else begin
							state_q     <= ST_SWEEP;
							tgt_q       <= target_sum;
							die_q       <= VW'(1);
							s_q         <= VW'(1);
							bank_q      <= 1'b0;
							first_die_q <= 1'b1;
						end
					end
				end
				ST_SWEEP: begin
					v_s1       <= 1'b1;
					waddr_s1   <= s_q[AW-1:0];
					wbank_s1   <= ~bank_q;
					first_s1   <= (s_q == VW'(1));
					last_s1    <= last_s & last_die;
					force_a_s1 <= force_a;
					aval_s1    <= aval;
					force_b_s1 <= force_b;
					bval_s1    <= bval;
					if (last_s) begin
						if (last_die) begin
							state_q <= ST_DRAIN;
						end else begin
							die_q       <= die_q + VW'(1);
							s_q         <= VW'(1);
							bank_q      <= ~bank_q;
							first_die_q <= 1'b0;
						end
					end else begin
						s_q <= s_q + VW'(1);
					end
				end
				ST_DRAIN: begin
					// final entry is computed this cycle
					if (v_s1 && last_s1) begin
						done_q  <= 1'b1;
						way_q   <= win_next;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign done      = done_q;
	assign way_count = way_q;

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;
	import dsw_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start;
	logic [VAL_W-1:0]    target_sum;
	logic                busy;
	logic                done;
	logic [CNT_W-1:0]    way_count;

	logic [VAL_W-1:0]    face_setting;
	logic [VAL_W-1:0]    dice_setting;
	logic [CNT_W-1:0]    expected_ways[$];
	int                  n_errors;
	int                  n_cmds;
	int                  n_counts;
	int                  n_writes;
	int                  n_nonzero;

	dice_sum_way_counter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start      (start),
		.target_sum (target_sum),
		.busy       (busy),
		.done       (done),
		.way_count  (way_count)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#150_000_000;
		$display("FAIL dice_sum_way_counter");
		$finish;
	end

	// Ordered ways for dice showing 1..faces to total target, two rolling rows
	function automatic logic [CNT_W-1:0] count_ways(logic [VAL_W-1:0] faces,
			logic [VAL_W-1:0] dice, logic [VAL_W-1:0] target);
		logic [CNT_W-1:0] prev_ways[0:SUM_MAX];
		logic [CNT_W-1:0] cur_ways[0:SUM_MAX];
		logic [CNT_W-1:0] acc;
		int d;
		int s;
		int k;
		if (int'(target) > SUM_MAX) begin
			return '0;
		end
		for (s = 0; s <= int'(target); s++) begin
			prev_ways[s] = '0;
		end
		prev_ways[0] = CNT_W'(1);
		for (d = 1; d <= int'(dice); d++) begin
			cur_ways[0] = '0;
			for (s = 1; s <= int'(target); s++) begin
				acc = '0;
				for (k = 1; k <= int'(faces) && k <= s; k++) begin
					acc += prev_ways[s - k];
				end
				cur_ways[s] = acc;
			end
			for (s = 0; s <= int'(target); s++) begin
				prev_ways[s] = cur_ways[s];
			end
		end
		return prev_ways[target];
	endfunction

	task automatic note_error(string msg);
		if (n_errors < 10) begin
			$display("%t ERROR %s", $realtime, msg);
		end
		n_errors++;
	endtask

	// Compare each count strobe against the oldest pending expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_ways.size() == 0) begin
				note_error($sformatf("unexpected count %0d", way_count));
			end else begin
				if (way_count !== expected_ways[0]) begin
					note_error($sformatf("way_count expected %0d got %0d",
						expected_ways[0], way_count));
				end
				if (expected_ways[0] != 0) begin
					n_nonzero++;
				end
				void'(expected_ways.pop_front());
				n_counts++;
			end
		end
	end

	task automatic send_target(logic [VAL_W-1:0] t);
		@(negedge clk);
		start <= 1'b1;
		target_sum <= t;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		expected_ways.push_back(count_ways(face_setting, dice_setting, t));
		n_cmds++;
	endtask

	// Idle the command side; sometimes let the block finish first
	task automatic command_gap();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			n = 0;
		end else if (r < 88) begin
			n = $urandom_range(1, 4);
		end else begin
			n = $urandom_range(10, 60);
		end
		if (n > 0) begin
			@(negedge clk);
			start <= 1'b0;
			if ($urandom_range(0, 1) == 1) begin
				@(posedge clk);
				while (busy) begin
					@(posedge clk);
				end
			end
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Drop start and wait until all counts are back and the block is idle
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		@(posedge clk);
		while (expected_ways.size() != 0 || busy) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic reg_idx, logic [VAL_W-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= {(DATA_W - VAL_W)'($urandom()), val};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		if (reg_idx == REG_FACE) begin
			face_setting = val;
		end else begin
			dice_setting = val;
		end
		n_writes++;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic reg_read(logic reg_idx);
		logic [VAL_W-1:0] want;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {reg_idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		want = (reg_idx == REG_FACE) ? face_setting : dice_setting;
		if (prdata[VAL_W-1:0] !== want) begin
			note_error($sformatf("register %0d read expected %0d got %0d",
				reg_idx, want, prdata[VAL_W-1:0]));
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_dice(logic [VAL_W-1:0] faces, logic [VAL_W-1:0] dice);
		settle();
		reg_write(REG_FACE, faces);
		reg_write(REG_DICE, dice);
		reg_read(REG_FACE);
		reg_read(REG_DICE);
	endtask

	task automatic test_reset_defaults();
		reg_read(REG_FACE);
		reg_read(REG_DICE);
		send_target(7'd0);
		send_target(7'd2);
		send_target(7'd3);
		command_gap();
		send_target(7'd10);
		send_target(7'd18);
		send_target(7'd19);
		send_target(7'd64);
	endtask

	task automatic test_target_extremes();
		set_dice(7'd64, 7'd64);
		send_target(7'd64);
		send_target(7'd63);
		send_target(7'd65);
		send_target(7'd127);
		set_dice(7'd1, 7'd1);
		send_target(7'd1);
		send_target(7'd2);
	endtask

	task automatic test_special_cases();
		// no dice: only target zero is reachable
		set_dice(7'd6, 7'd0);
		send_target(7'd0);
		send_target(7'd5);
		// no faces at all
		set_dice(7'd0, 7'd2);
		send_target(7'd2);
		// window wider than the target
		set_dice(7'd127, 7'd2);
		send_target(7'd10);
		set_dice(7'd64, 7'd1);
		send_target(7'd64);
		// more dice than any sum can hold
		set_dice(7'd64, 7'd65);
		send_target(7'd64);
		set_dice(7'd127, 7'd127);
		send_target(7'd64);
	endtask

	function automatic logic [VAL_W-1:0] pick_setting();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			return VAL_W'($urandom_range(1, 12));
		end else if (r < 85) begin
			return VAL_W'($urandom_range(13, 64));
		end
		case ($urandom_range(0, 3))
			0: return VAL_W'(0);
			1: return VAL_W'(1);
			2: return VAL_W'(64);
			default: return VAL_W'(127);
		endcase
	endfunction

	function automatic logic [VAL_W-1:0] pick_target();
		int r;
		int lo;
		int hi;
		r = $urandom_range(0, 99);
		lo = int'(dice_setting);
		hi = int'(dice_setting) * int'(face_setting);
		if (hi > SUM_MAX) begin
			hi = SUM_MAX;
		end
		// favor the band where counts are nonzero
		if (r < 50 && lo >= 1 && lo <= hi) begin
			return VAL_W'($urandom_range(lo, hi));
		end else if (r < 88) begin
			return VAL_W'($urandom_range(0, SUM_MAX));
		end
		return VAL_W'($urandom_range(SUM_MAX + 1, 127));
	endfunction

	task automatic test_random();
		int p;
		int i;
		for (p = 0; p < 6; p++) begin
			set_dice(pick_setting(), pick_setting());
			for (i = 0; i < 20; i++) begin
				command_gap();
				send_target(pick_target());
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		start = 1'b0;
		target_sum = '0;
		face_setting = FACE_RESET;
		dice_setting = DICE_RESET;
		n_errors = 0;
		n_cmds = 0;
		n_counts = 0;
		n_writes = 0;
		n_nonzero = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_target_extremes();
		test_special_cases();
		test_random();

		settle();
		repeat (20) @(posedge clk);
		if (expected_ways.size() != 0) begin
			note_error($sformatf("%0d counts never arrived", expected_ways.size()));
		end
		$display("Ran %0d commands, checked %0d counts (%0d nonzero)",
			n_cmds, n_counts, n_nonzero);
		$display("over %0d register writes, face and dice counts from 0 to 127",
			n_writes);
		if (n_errors == 0) begin
			$display("PASS dice_sum_way_counter");
		end else begin
			$display("FAIL dice_sum_way_counter");
		end
		$finish;
	end

endmodule
